// ----- hw/rtl/albd_pkg.sv -----
// Package for the ambient level from box distance unit.
// Shared opcodes, box coordinate indexes and fixed-point distance/level constants.
// No dependencies.
package albd_pkg;

	// Request opcodes
	typedef enum logic {
		OP_START  = 1'b0,
		OP_SOURCE = 1'b1
	} opcode_t;

	// Default configuration of the top level
	localparam int NUM_CLASSES_DEF = 4;
	localparam int COORD_WIDTH_DEF = 24;

	// Box layout: min x,y,z then max x,y,z
	localparam int NUM_AXES   = 3;
	localparam int BOX_COORDS = 2 * NUM_AXES;
	localparam int IDX_MIN_X  = 0;
	localparam int IDX_MIN_Y  = 1;
	localparam int IDX_MIN_Z  = 2;
	localparam int IDX_MAX_X  = 3;
	localparam int IDX_MAX_Y  = 4;
	localparam int IDX_MAX_Z  = 5;

	// Distances in 1/16 unit steps; never above 1020 units
	localparam int DIST_WIDTH = 14;
	localparam logic [DIST_WIDTH-1:0] FAR_DISTANCE = 14'd16320;
	localparam logic [DIST_WIDTH-1:0] NEAR_LIMIT   = 14'd1600;
	localparam logic [DIST_WIDTH-1:0] ZERO_LIMIT   = 14'd8000;

	// Levels
	localparam int LEVEL_WIDTH      = 8;
	localparam int NUM_LEVEL_FIELDS = 4;
	localparam logic [LEVEL_WIDTH-1:0] FULL_LEVEL     = 8'd255;
	localparam logic [LEVEL_WIDTH-1:0] MAX_RAMP_LEVEL = 8'd204;

	// Ramp math: span in 13 bits, 255*span in 21 bits, >>6 leaves 15 bits,
	// then /125 through a reciprocal multiply (exact for all quotients here)
	localparam int SPAN_WIDTH   = 13;
	localparam int SCALED_WIDTH = 21;
	localparam int QUOT_SHIFT   = 6;
	localparam int QUOT_WIDTH   = SCALED_WIDTH - QUOT_SHIFT;
	localparam int RECIP_WIDTH  = 16;
	localparam int RECIP_SHIFT  = 22;
	localparam logic [RECIP_WIDTH-1:0] RECIP_125 = 16'd33555;
	localparam int PROD_WIDTH   = QUOT_WIDTH + RECIP_WIDTH;

endpackage

// ----- hw/rtl/albd_in_if.sv -----
// Input channel of the ambient level unit: valid/ready plus one request.
// Depends on nothing; coordinate width is an interface parameter.
interface albd_in_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [COORD_WIDTH-1:0] box_min_x;
	logic signed [COORD_WIDTH-1:0] box_min_y;
	logic signed [COORD_WIDTH-1:0] box_min_z;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;
	logic [1:0]                    sound_class;
	logic                          visible;
	logic                          last;

	modport source (
		output valid, opcode, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z, sound_class, visible, last,
		input  ready
	);
	modport sink (
		input  valid, opcode, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z, sound_class, visible, last,
		output ready
	);
endinterface

// ----- hw/rtl/albd_out_if.sv -----
// Output channel of the ambient level unit: valid/ready plus four levels.
// Depends on nothing.
interface albd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] level_class0;
	logic [7:0] level_class1;
	logic [7:0] level_class2;
	logic [7:0] level_class3;

	modport source (
		output valid, level_class0, level_class1, level_class2, level_class3,
		input  ready
	);
	modport sink (
		input  valid, level_class0, level_class1, level_class2, level_class3,
		output ready
	);
endinterface

// ----- hw/rtl/albd_gap.sv -----
// Box gap: largest per-axis separation between a source and the target box.
// Depends on albd_pkg for the box layout.
module albd_gap #(
	parameter int COORD_WIDTH = albd_pkg::COORD_WIDTH_DEF
) (
	input  logic signed [COORD_WIDTH-1:0] src_box [albd_pkg::BOX_COORDS],
	input  logic signed [COORD_WIDTH-1:0] tgt_box [albd_pkg::BOX_COORDS],
	output logic        [COORD_WIDTH:0]   gap
);

	logic [COORD_WIDTH:0] axis_gap [albd_pkg::NUM_AXES];

	// Per-axis gap; "source above target" is tested first
	always_comb begin
		for (int a = 0; a < albd_pkg::NUM_AXES; a++) begin
			if (src_box[a] > tgt_box[a + albd_pkg::NUM_AXES]) begin
				axis_gap[a] = COORD_WIDTH'(0) + (COORD_WIDTH + 1)'(
					{src_box[a][COORD_WIDTH-1], src_box[a]} -
					{tgt_box[a + albd_pkg::NUM_AXES][COORD_WIDTH-1],
					 tgt_box[a + albd_pkg::NUM_AXES]});
			end else if (src_box[a + albd_pkg::NUM_AXES] < tgt_box[a]) begin
				axis_gap[a] = (COORD_WIDTH + 1)'(
					{tgt_box[a][COORD_WIDTH-1], tgt_box[a]} -
					{src_box[a + albd_pkg::NUM_AXES][COORD_WIDTH-1],
					 src_box[a + albd_pkg::NUM_AXES]});
			end else begin
				axis_gap[a] = '0;
			end
		end
	end

	// Max over the three axes
	always_comb begin
		gap = axis_gap[0];
		for (int a = 1; a < albd_pkg::NUM_AXES; a++) begin
			if (axis_gap[a] > gap) begin
				gap = axis_gap[a];
			end
		end
	end

endmodule

// ----- hw/rtl/albd_level.sv -----
// Distance to ambient level: 255 when near, 0 when far, linear ramp between.
// Depends on albd_pkg for limits and the reciprocal constant.
module albd_level (
	input  logic [albd_pkg::DIST_WIDTH-1:0]  distance,
	output logic [albd_pkg::LEVEL_WIDTH-1:0] level
);

	logic [albd_pkg::DIST_WIDTH-1:0]   span_full;
	logic [albd_pkg::SPAN_WIDTH-1:0]   span;
	logic [albd_pkg::SCALED_WIDTH-1:0] scaled;
	logic [albd_pkg::QUOT_WIDTH-1:0]   quot;
	logic [albd_pkg::PROD_WIDTH-1:0]   prod;

	// 255*(8000-d)/8000 = ((255*span) >> 6) / 125
	assign span_full = albd_pkg::ZERO_LIMIT - distance;
	assign span      = span_full[albd_pkg::SPAN_WIDTH-1:0];
	assign scaled    = {span, 8'b0} - albd_pkg::SCALED_WIDTH'(span);
	assign quot      = scaled[albd_pkg::SCALED_WIDTH-1:albd_pkg::QUOT_SHIFT];
	assign prod      = albd_pkg::PROD_WIDTH'(quot) *
		albd_pkg::PROD_WIDTH'(albd_pkg::RECIP_125);

	always_comb begin
		if (distance < albd_pkg::NEAR_LIMIT) begin
			level = albd_pkg::FULL_LEVEL;
		end else if (distance >= albd_pkg::ZERO_LIMIT) begin
			level = '0;
		end else begin
			level = prod[albd_pkg::RECIP_SHIFT +: albd_pkg::LEVEL_WIDTH];
		end
	end

endmodule

// ----- hw/rtl/ambient_level_from_box_distance_unit.sv -----
// Ambient level from box distance: top level with input, state and result registers.
// Depends on albd_pkg, albd_in_if, albd_out_if, albd_gap and albd_level.
//
// Takes one request per clock while ready is high. A start request loads
// the target box and resets the per-class nearest distances; a visible
// source request folds its box gap into its class minimum as it leaves the
// input register. A request with last set puts its result on the output
// through three registers: input register, distance snapshot register,
// level register. Input backpressure appears only when a last request is
// held behind a full snapshot stage and an unaccepted result; otherwise
// ready stays high.
module ambient_level_from_box_distance_unit #(
	parameter int NUM_CLASSES = albd_pkg::NUM_CLASSES_DEF,
	parameter int COORD_WIDTH = albd_pkg::COORD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	albd_in_if.sink           in_ch,
	albd_out_if.source        out_ch
);

	localparam int NUM_OUT = (NUM_CLASSES < albd_pkg::NUM_LEVEL_FIELDS) ?
		NUM_CLASSES : albd_pkg::NUM_LEVEL_FIELDS;

	// Input stage
	logic                          valid_s1;
	albd_pkg::opcode_t             op_s1;
	logic signed [COORD_WIDTH-1:0] box_s1 [albd_pkg::BOX_COORDS];
	logic [1:0]                    cls_s1;
	logic                          vis_s1;
	logic                          last_s1;

	// Stored state
	logic signed [COORD_WIDTH-1:0]    target_q [albd_pkg::BOX_COORDS];
	logic [albd_pkg::DIST_WIDTH-1:0]  dist_q    [NUM_CLASSES];
	logic [albd_pkg::DIST_WIDTH-1:0]  dist_next [NUM_CLASSES];

	// Snapshot stage and result register
	logic                             valid_s2;
	logic [albd_pkg::DIST_WIDTH-1:0]  dist_s2 [NUM_CLASSES];
	logic                             out_valid_q;
	logic [albd_pkg::LEVEL_WIDTH-1:0] level_q    [albd_pkg::NUM_LEVEL_FIELDS];
	logic [albd_pkg::LEVEL_WIDTH-1:0] level_comb [albd_pkg::NUM_LEVEL_FIELDS];

	logic [COORD_WIDTH:0] gap;
	logic out_free, s2_free, s1_adv, in_fire;

	// Flow control
	assign out_free    = !out_valid_q || out_ch.ready;
	assign s2_free     = !valid_s2 || out_free;
	assign s1_adv      = valid_s1 && (!last_s1 || s2_free);
	assign in_ch.ready = !valid_s1 || s1_adv;
	assign in_fire     = in_ch.valid && in_ch.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= albd_pkg::opcode_t'(in_ch.opcode);
			box_s1[albd_pkg::IDX_MIN_X] <= in_ch.box_min_x;
			box_s1[albd_pkg::IDX_MIN_Y] <= in_ch.box_min_y;
			box_s1[albd_pkg::IDX_MIN_Z] <= in_ch.box_min_z;
			box_s1[albd_pkg::IDX_MAX_X] <= in_ch.box_max_x;
			box_s1[albd_pkg::IDX_MAX_Y] <= in_ch.box_max_y;
			box_s1[albd_pkg::IDX_MAX_Z] <= in_ch.box_max_z;
			cls_s1  <= in_ch.sound_class;
			vis_s1  <= in_ch.visible;
			last_s1 <= in_ch.last;
		end
	end

	// Gap against the current target
	albd_gap #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_gap (
		.src_box(box_s1),
		.tgt_box(target_q),
		.gap    (gap)
	);

	// Next per-class distance
	always_comb begin
		for (int j = 0; j < NUM_CLASSES; j++) begin
			dist_next[j] = dist_q[j];
			if (op_s1 == albd_pkg::OP_START) begin
				dist_next[j] = albd_pkg::FAR_DISTANCE;
			end else if (vis_s1 && (int'(cls_s1) == j) &&
			             (gap < (COORD_WIDTH + 1)'(dist_q[j]))) begin
				dist_next[j] = gap[albd_pkg::DIST_WIDTH-1:0];
			end
		end
	end

	// State update as the request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < albd_pkg::BOX_COORDS; i++) begin
				target_q[i] <= '0;
			end
			for (int j = 0; j < NUM_CLASSES; j++) begin
				dist_q[j] <= albd_pkg::FAR_DISTANCE;
			end
		end else if (s1_adv) begin
			if (op_s1 == albd_pkg::OP_START) begin
				target_q <= box_s1;
			end
			dist_q <= dist_next;
		end
	end

	// Distance snapshot for a last request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && last_s1) begin
			dist_s2 <= dist_next;
		end
	end

	// Level conversion per output field
	for (genvar i = 0; i < albd_pkg::NUM_LEVEL_FIELDS; i++) begin : g_lvl
		if (i < NUM_OUT) begin : g_on
			albd_level u_level (
				.distance(dist_s2[i]),
				.level   (level_comb[i])
			);
		end else begin : g_off
			assign level_comb[i] = '0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			level_q <= level_comb;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.level_class0 = level_q[0];
	assign out_ch.level_class1 = level_q[1];
	assign out_ch.level_class2 = level_q[2];
	assign out_ch.level_class3 = level_q[3];

endmodule

// ----- hw/rtl/albd_checker.sv -----
// Port-level checker for the ambient level unit, bound to the top level.
// Depends on albd_pkg and ambient_level_from_box_distance_unit.
module albd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] level_class0,
	input logic [7:0] level_class1,
	input logic [7:0] level_class2,
	input logic [7:0] level_class3
);

	// A pending result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before accept");

	// A stalled result keeps its levels
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(level_class0) && $stable(level_class1) &&
			$stable(level_class2) && $stable(level_class3))
		else $error("stalled result changed");

	// Levels are full or on the ramp, never between ramp top and full
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(level_class0 <= albd_pkg::MAX_RAMP_LEVEL ||
			 level_class0 == albd_pkg::FULL_LEVEL) &&
			(level_class1 <= albd_pkg::MAX_RAMP_LEVEL ||
			 level_class1 == albd_pkg::FULL_LEVEL) &&
			(level_class2 <= albd_pkg::MAX_RAMP_LEVEL ||
			 level_class2 == albd_pkg::FULL_LEVEL) &&
			(level_class3 <= albd_pkg::MAX_RAMP_LEVEL ||
			 level_class3 == albd_pkg::FULL_LEVEL))
		else $error("level outside conversion range");

	// Input backpressure only when the output itself is stalled
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

endmodule

bind ambient_level_from_box_distance_unit albd_checker u_albd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.level_class0(out_ch.level_class0),
	.level_class1(out_ch.level_class1),
	.level_class2(out_ch.level_class2),
	.level_class3(out_ch.level_class3)
);
